### rtl/core/bfe_pkg.sv
// Package for the Bloom filter engine: sizes, register indexes, job and status types
// and the MurmurHash3 constants and rotate helper. Depends on nothing.
package bfe_pkg;

  localparam int MAX_KEY_BYTES = 64;
  localparam int STORE_BYTES   = 1024;

  localparam int KEY_AW   = $clog2(MAX_KEY_BYTES);
  localparam int LEN_W    = $clog2(MAX_KEY_BYTES + 1);
  localparam int STORE_AW = $clog2(STORE_BYTES);
  localparam int NBITS_W  = $clog2(8 * STORE_BYTES + 1);
  localparam int FB_W     = 11;
  localparam int HC_W     = 5;
  localparam int CFG_W    = 11;
  localparam int CFG_IW   = 2;

  localparam logic [CFG_IW-1:0] REG_HASH_COUNT   = 2'd0;
  localparam logic [CFG_IW-1:0] REG_FILTER_BYTES = 2'd1;

  localparam logic [HC_W-1:0] HASH_COUNT_RESET   = 5'd7;
  localparam logic [FB_W-1:0] FILTER_BYTES_RESET = 11'd1024;

  localparam logic [31:0] MIX_C1 = 32'hcc9e2d51;
  localparam logic [31:0] MIX_C2 = 32'h1b873593;
  localparam logic [31:0] MIX_C3 = 32'h85ebca6b;
  localparam logic [31:0] MIX_C4 = 32'hc2b2ae35;
  localparam logic [31:0] MIX_ADD = 32'he6546b64;

  localparam logic ACT_ADD   = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef struct packed {
    logic             action;
    logic [LEN_W-1:0] len;
    logic             overflow;
  } job_t;

  typedef struct packed {
    logic release_buf;
    logic clear_done;
  } back_status_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
    rotl = (x << r) | (x >> (32 - r));
  endfunction

endpackage

### rtl/core/bfe_if.sv
// Channel interfaces of the Bloom filter engine: key bytes in, results out.
// Depends on nothing.
interface bfe_in_if;
  logic valid;
  logic ready;
  logic action;
  logic [7:0] key_byte;
  logic has_byte;
  logic last_byte;
  modport source (output valid, action, key_byte, has_byte, last_byte, input ready);
  modport sink (input valid, action, key_byte, has_byte, last_byte, output ready);
endinterface

interface bfe_out_if;
  logic valid;
  logic ready;
  logic done_action;
  logic may_contain;
  logic key_too_long;
  modport source (output valid, done_action, may_contain, key_too_long, input ready);
  modport sink (input valid, done_action, may_contain, key_too_long, output ready);
endinterface

### rtl/core/bfe_queue.sv
// Two-entry job queue between the front and back parts.
// Depends on bfe_pkg.
module bfe_queue import bfe_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output job_t head
);

  job_t slots [2];
  logic wptr, rptr;
  logic [1:0] count;

  assign full = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

### rtl/core/bfe_front.sv
// Front part: takes key bytes, keeps the key buffer and queues one job per key.
// Depends on bfe_pkg and bfe_if.
module bfe_front import bfe_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  bfe_in_if.sink            in_ch,
  input  logic              q_full,
  output logic              push,
  output job_t              push_job,
  input  back_status_t      status,
  input  logic [KEY_AW-1:0] key_raddr,
  output logic [7:0]        key_rdata
);

  logic [7:0] key_mem [MAX_KEY_BYTES];
  logic [LEN_W-1:0] len;
  logic overflow;
  logic busy;
  logic take;
  logic room;

  // The buffer is held by the back part until it has hashed the key.
  assign in_ch.ready = status.clear_done & ~busy & ~q_full;
  assign take = in_ch.valid & in_ch.ready;
  assign room = (len < LEN_W'(MAX_KEY_BYTES));

  assign push = take & in_ch.last_byte;
  assign push_job.action = in_ch.action;
  assign push_job.len = len + LEN_W'(in_ch.has_byte & room);
  assign push_job.overflow = overflow | (in_ch.has_byte & ~room);

  always_ff @(posedge clk) begin
    if (take && in_ch.has_byte && room) begin
      key_mem[len[KEY_AW-1:0]] <= in_ch.key_byte;
    end
    key_rdata <= key_mem[key_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
      overflow <= 1'b0;
      busy <= 1'b0;
    end else begin
      if (take) begin
        if (in_ch.last_byte) begin
          len <= '0;
          overflow <= 1'b0;
        end else if (in_ch.has_byte) begin
          if (room) len <= len + 1'b1;
          else overflow <= 1'b1;
        end
      end
      if (push) busy <= 1'b1;
      else if (status.release_buf) busy <= 1'b0;
    end
  end

endmodule

### rtl/core/bfe_back.sv
// Back part: hashes a queued key twice, reduces the hashes, probes the bit store
// and holds the result. Depends on bfe_pkg and bfe_if.
module bfe_back import bfe_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              q_not_empty,
  input  job_t              q_head,
  output logic              pop,
  output back_status_t      status,
  output logic [KEY_AW-1:0] key_raddr,
  input  logic [7:0]        key_rdata,
  bfe_out_if.source         out_ch
);

  typedef enum logic [13:0] {
    S_CLR   = 14'b00000000000001,
    S_IDLE  = 14'b00000000000010,
    S_START = 14'b00000000000100,
    S_FETCH = 14'b00000000001000,
    S_LATCH = 14'b00000000010000,
    S_K1    = 14'b00000000100000,
    S_K2    = 14'b00000001000000,
    S_MIX   = 14'b00000010000000,
    S_FIN1  = 14'b00000100000000,
    S_FIN2  = 14'b00001000000000,
    S_FIN3  = 14'b00010000000000,
    S_MOD   = 14'b00100000000000,
    S_PRD   = 14'b01000000000000,
    S_PWR   = 14'b10000000000000
  } state_t;

  state_t state;
  logic [HC_W-1:0] hash_count;
  logic [FB_W-1:0] filter_bytes;
  job_t job;
  logic [31:0] h, k, word, h1, h2;
  logic [LEN_W-1:0] ptr;
  logic [1:0] lane;
  logic full_blk, pass;
  logic [4:0] bitcnt;
  logic [NBITS_W-1:0] r1, r2, pos;
  logic [HC_W-1:0] probe;
  logic all_set;
  logic [STORE_AW-1:0] clr_cnt;
  logic [7:0] store [STORE_BYTES];
  logic [7:0] st_rd;
  logic st_we;
  logic [STORE_AW-1:0] st_waddr;
  logic [7:0] st_wdata;
  logic ov, o_act, o_may, o_long;
  logic [FB_W-1:0] fb_c;
  logic [NBITS_W-1:0] nbits;
  logic [31:0] fin_t, fin2_t, fin3_t, mix_t;
  logic [NBITS_W:0] pos_sum;
  logic bit_ok;

  function automatic logic [NBITS_W-1:0] mod_step(input logic [NBITS_W-1:0] r,
                                                  input logic b,
                                                  input logic [NBITS_W-1:0] n);
    logic [NBITS_W:0] t;
    t = {r, b};
    if (t >= {1'b0, n}) t = t - {1'b0, n};
    mod_step = t[NBITS_W-1:0];
  endfunction

  always_comb begin
    if (filter_bytes < FB_W'(8)) fb_c = FB_W'(8);
    else if (filter_bytes > FB_W'(STORE_BYTES)) fb_c = FB_W'(STORE_BYTES);
    else fb_c = filter_bytes;
  end
  assign nbits = {fb_c[NBITS_W-4:0], 3'b000};

  assign fin_t  = (h ^ {{(32-LEN_W){1'b0}}, job.len}) ^ ((h ^ {{(32-LEN_W){1'b0}}, job.len}) >> 16);
  assign fin2_t = h ^ (h >> 13);
  assign fin3_t = h ^ (h >> 16);
  assign mix_t  = h ^ k;
  assign pos_sum = {1'b0, pos} + {1'b0, r2};
  assign bit_ok = st_rd[pos[2:0]];

  assign status.clear_done = (state != S_CLR);
  assign status.release_buf = ((state == S_FIN3) && pass) ||
                              ((state == S_IDLE) && pop && q_head.overflow);
  assign pop = (state == S_IDLE) && q_not_empty && !ov;
  assign key_raddr = ptr[KEY_AW-1:0];

  assign out_ch.valid = ov;
  assign out_ch.done_action = o_act;
  assign out_ch.may_contain = o_may;
  assign out_ch.key_too_long = o_long;

  always_comb begin
    st_we = 1'b0;
    st_waddr = pos[STORE_AW+2:3];
    st_wdata = st_rd | (8'd1 << pos[2:0]);
    if (state == S_CLR) begin
      st_we = 1'b1;
      st_waddr = clr_cnt;
      st_wdata = 8'd0;
    end else if (state == S_PWR && job.action == ACT_ADD) begin
      st_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) store[st_waddr] <= st_wdata;
    st_rd <= store[pos[STORE_AW+2:3]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_count <= HASH_COUNT_RESET;
      filter_bytes <= FILTER_BYTES_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HASH_COUNT:   hash_count <= cfg_data[HC_W-1:0];
        REG_FILTER_BYTES: filter_bytes <= cfg_data[FB_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr_cnt <= '0;
      ov <= 1'b0;
    end else begin
      if (ov && out_ch.ready) ov <= 1'b0;
      unique case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == STORE_AW'(STORE_BYTES - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (pop) begin
            job <= q_head;
            if (q_head.overflow) begin
              ov <= 1'b1;
              o_act <= q_head.action;
              o_may <= 1'b0;
              o_long <= 1'b1;
            end else begin
              h <= '0;
              ptr <= '0;
              pass <= 1'b0;
              state <= S_START;
            end
          end
        end
        S_START: begin
          word <= '0;
          lane <= '0;
          state <= (ptr == job.len) ? S_FIN1 : S_FETCH;
        end
        S_FETCH: state <= S_LATCH;
        S_LATCH: begin
          word <= word | ({24'd0, key_rdata} << {lane, 3'b000});
          full_blk <= (lane == 2'd3);
          ptr <= ptr + 1'b1;
          lane <= lane + 1'b1;
          if (lane == 2'd3 || (ptr + 1'b1) == job.len) state <= S_K1;
          else state <= S_FETCH;
        end
        S_K1: begin
          k <= word * MIX_C1;
          state <= S_K2;
        end
        S_K2: begin
          k <= rotl(k, 15) * MIX_C2;
          state <= S_MIX;
        end
        S_MIX: begin
          if (full_blk) begin
            h <= (rotl(mix_t, 13) << 2) + rotl(mix_t, 13) + MIX_ADD;
            state <= S_START;
          end else begin
            h <= mix_t;
            state <= S_FIN1;
          end
        end
        S_FIN1: begin
          h <= fin_t * MIX_C3;
          state <= S_FIN2;
        end
        S_FIN2: begin
          h <= fin2_t * MIX_C4;
          state <= S_FIN3;
        end
        S_FIN3: begin
          if (!pass) begin
            h1 <= fin3_t;
            h <= fin3_t;
            ptr <= '0;
            pass <= 1'b1;
            state <= S_START;
          end else begin
            h2 <= fin3_t;
            r1 <= '0;
            r2 <= '0;
            bitcnt <= '0;
            state <= S_MOD;
          end
        end
        S_MOD: begin
          // One remainder bit per cycle for both hashes.
          r1 <= mod_step(r1, h1[31], nbits);
          r2 <= mod_step(r2, h2[31], nbits);
          h1 <= h1 << 1;
          h2 <= h2 << 1;
          bitcnt <= bitcnt + 1'b1;
          if (bitcnt == 5'd31) begin
            pos <= mod_step(r1, h1[31], nbits);
            probe <= '0;
            all_set <= 1'b1;
            if (hash_count == '0) begin
              ov <= 1'b1;
              o_act <= job.action;
              o_may <= (job.action == ACT_QUERY);
              o_long <= 1'b0;
              state <= S_IDLE;
            end else begin
              state <= S_PRD;
            end
          end
        end
        S_PRD: state <= S_PWR;
        S_PWR: begin
          all_set <= all_set & bit_ok;
          probe <= probe + 1'b1;
          if (pos_sum >= {1'b0, nbits}) pos <= pos_sum[NBITS_W-1:0] - nbits;
          else pos <= pos_sum[NBITS_W-1:0];
          if (probe == hash_count - 1'b1) begin
            ov <= 1'b1;
            o_act <= job.action;
            o_may <= (job.action == ACT_QUERY) & all_set & bit_ok;
            o_long <= 1'b0;
            state <= S_IDLE;
          end else begin
            state <= S_PRD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_probe_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_PRD) |-> (pos < nbits))
    else $error("probe position beyond filter size");

  a_pop_slot_free: assert property (@(posedge clk) disable iff (rst)
    pop |-> !ov)
    else $error("job taken while a result still waits");

  a_no_item_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLR) |-> !pop)
    else $error("job taken during clearing pass");

endmodule

### rtl/core/bloom_filter_engine.sv
// Top level of the Bloom filter engine.
// Depends on bfe_pkg, bfe_if, bfe_queue, bfe_front and bfe_back.

// A key arrives as items of one byte each on in_ch; the item with last_byte
// set ends the key and carries the action (add or query). After reset the
// block clears the STORE_BYTES (1024) bytes of the bit store and takes no
// item until that pass is over; configuration writes are taken meanwhile.
// Key bytes are taken one per cycle while in_ch.ready is high. After the last
// byte the back part runs MurmurHash3 twice over the buffered key, with a
// byte fetch per byte and a scramble per block plus a finish per pass, then
// a bit-serial reduction of both hashes, then the states S_PRD and S_PWR for
// each probe on the single bit-store port. The front holds off the next key
// until the second hash pass has finished with the buffer. A key over 64
// bytes is answered with key_too_long without being hashed.
module bloom_filter_engine import bfe_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  bfe_in_if.sink            in_ch,
  bfe_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  // Jobs from the front part wait here until the back part is free.
  logic push, pop, q_full, q_not_empty;
  job_t push_job, q_head;
  back_status_t status;
  logic [KEY_AW-1:0] key_raddr;
  logic [7:0] key_rdata;

  bfe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .push      (push),
    .push_job  (push_job),
    .status    (status),
    .key_raddr (key_raddr),
    .key_rdata (key_rdata)
  );

  bfe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // The back part owns the configuration registers and the bit store.
  bfe_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .pop         (pop),
    .status      (status),
    .key_raddr   (key_raddr),
    .key_rdata   (key_rdata),
    .out_ch      (out_ch)
  );

endmodule

### dv/bloom_filter_engine_tb.sv
// Self-checking testbench for bloom_filter_engine: keys go in as byte items and
// add/query answers are predicted and checked. Depends on bfe_pkg and the
// bfe_in_if/bfe_out_if interfaces from the RTL.
`timescale 1ns / 100ps

module bloom_filter_engine_tb;
  import bfe_pkg::*;

  localparam int IDLE_GAP = 600;  // Longer than the slowest key through the back part.

  typedef struct {
    logic       action;
    logic [7:0] key_byte;
    logic       has_byte;
    logic       last_byte;
  } key_item_t;

  typedef struct {
    logic done_action;
    logic may_contain;
    logic key_too_long;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  bfe_in_if in_ch ();
  bfe_out_if out_ch ();

  bloom_filter_engine dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Items waiting to be offered and answers waiting to arrive.
  key_item_t pending_items[$];
  answer_t   expected_answers[$];
  int        mismatches = 0;

  // Shadow of the block's state and registers.
  bit        shadow_bits [0:8*STORE_BYTES-1];
  bit [7:0]  shadow_key [0:MAX_KEY_BYTES-1];
  int        shadow_len = 0;
  bit        shadow_overflow = 1'b0;
  bit [4:0]  shadow_hash_count = HASH_COUNT_RESET;
  bit [10:0] shadow_filter_bytes = FILTER_BYTES_RESET;

  function automatic bit [31:0] rol32(input bit [31:0] x, input int r);
    return (x << r) | (x >> (32 - r));
  endfunction

  function automatic bit [31:0] scramble(input bit [31:0] k);
    return rol32(k * MIX_C1, 15) * MIX_C2;
  endfunction

  // MurmurHash3 x86_32 over the shadow key buffer.
  function automatic bit [31:0] murmur(input int n, input bit [31:0] seed);
    bit [31:0] h;
    bit [31:0] k;
    int base;
    h = seed;
    for (int b = 0; b < n / 4; b++) begin
      k = {shadow_key[4*b+3], shadow_key[4*b+2], shadow_key[4*b+1], shadow_key[4*b]};
      h = rol32(h ^ scramble(k), 13) * 32'd5 + MIX_ADD;
    end
    base = (n / 4) * 4;
    k = '0;
    if (n % 4 == 3) k ^= 32'(shadow_key[base+2]) << 16;
    if (n % 4 >= 2) k ^= 32'(shadow_key[base+1]) << 8;
    if (n % 4 >= 1) begin
      k ^= 32'(shadow_key[base]);
      h ^= scramble(k);
    end
    h ^= 32'(n);
    h ^= h >> 16;
    h *= MIX_C3;
    h ^= h >> 13;
    h *= MIX_C4;
    h ^= h >> 16;
    return h;
  endfunction

  // Applies one accepted item to the shadow state and queues the answer it causes.
  function automatic void predict_item(input key_item_t it);
    answer_t   ans;
    bit [31:0] h1;
    bit [31:0] h2;
    bit [63:0] nbits;
    bit [63:0] pos;
    int        fb;
    bit        all_set;
    if (it.has_byte) begin
      if (shadow_len < MAX_KEY_BYTES) begin
        shadow_key[shadow_len] = it.key_byte;
        shadow_len++;
      end else begin
        shadow_overflow = 1'b1;
      end
    end
    if (!it.last_byte) return;
    ans.done_action = it.action;
    ans.may_contain = 1'b0;
    ans.key_too_long = shadow_overflow;
    if (!shadow_overflow) begin
      fb = shadow_filter_bytes;
      if (fb < 8) fb = 8;
      if (fb > STORE_BYTES) fb = STORE_BYTES;
      nbits = 64'(fb) * 64'd8;
      h1 = murmur(shadow_len, 32'd0);
      h2 = murmur(shadow_len, h1);
      all_set = 1'b1;
      for (int i = 0; i < shadow_hash_count; i++) begin
        pos = (64'(h1) + 64'(i) * 64'(h2)) % nbits;
        if (it.action == ACT_ADD) shadow_bits[pos] = 1'b1;
        else if (!shadow_bits[pos]) all_set = 1'b0;
      end
      ans.may_contain = (it.action == ACT_QUERY) && all_set;
    end
    expected_answers.insert(expected_answers.size(), ans);
    shadow_len = 0;
    shadow_overflow = 1'b0;
  endfunction

  // Sender: acceptance is noted at the rising edge, the next item is put on the
  // wires at the falling edge. It works in bursts separated by random gaps.
  bit key_taken = 1'b0;
  int burst_left = 4;
  int gap_left = 0;
  key_item_t offered;

  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) begin
      predict_item(offered);
      key_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !key_taken) begin
      // Still waiting for the block to take the offered item.
    end else begin
      key_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        offered = pending_items.pop_front();
        in_ch.action <= offered.action;
        in_ch.key_byte <= offered.key_byte;
        in_ch.has_byte <= offered.has_byte;
        in_ch.last_byte <= offered.last_byte;
        in_ch.valid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          // Many bursts run back to back, so stretches without any gap occur too.
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.action = 1'b0;
    in_ch.key_byte = 8'h00;
    in_ch.has_byte = 1'b0;
    in_ch.last_byte = 1'b0;
    out_ch.ready = 1'b0;
  end

  // Receiver: it picks at random among four stall patterns. A long
  // hold-off is requested by the stimulus and counted down here.
  bit hold_request = 1'b0;
  int hold_left = 0;
  int rx_cycle = 0;
  int rx_mode = 0;

  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = 3000;
      hold_request = 1'b0;
    end
    rx_cycle++;
    if (rx_cycle % 250 == 0) rx_mode = $urandom_range(0, 3);
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= $urandom_range(0, 1);
        2: out_ch.ready <= ($urandom_range(0, 3) == 0);
        default: out_ch.ready <= ($urandom_range(0, 15) != 0);
      endcase
    end
  end

  // Answer checker: every accepted answer is compared with the oldest expectation.
  always @(posedge clk) begin
    answer_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_answers.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected answer action=%b may=%b long=%b", $time,
                 out_ch.done_action, out_ch.may_contain, out_ch.key_too_long);
      end else begin
        want = expected_answers.pop_front();
        if (out_ch.done_action !== want.done_action) begin
          mismatches++;
          $display("%0t: done_action expected %b actual %b", $time,
                   want.done_action, out_ch.done_action);
        end
        if (out_ch.may_contain !== want.may_contain) begin
          mismatches++;
          $display("%0t: may_contain expected %b actual %b", $time,
                   want.may_contain, out_ch.may_contain);
        end
        if (out_ch.key_too_long !== want.key_too_long) begin
          mismatches++;
          $display("%0t: key_too_long expected %b actual %b", $time,
                   want.key_too_long, out_ch.key_too_long);
        end
      end
    end
  end

  // Key content is derived from an id so that a key added earlier can be queried
  // again. Id 0 gives all-zero bytes and id 1 all-ones bytes.
  function automatic bit [7:0] key_content(input int id, input int j);
    bit [31:0] m;
    if (id == 0) return 8'h00;
    if (id == 1) return 8'hff;
    m = 32'(id) * 32'h9e3779b1 + 32'(j) * 32'h85ebca77;
    return m[23:16] ^ m[7:0];
  endfunction

  int items_queued = 0;
  int known_ids[$];

  // Queues one key: its bytes, optionally with empty filler items in between,
  // and the action on the final item. Non-final items carry a random action.
  task automatic queue_key(input logic act, input int id, input int len, input bit filler);
    key_item_t it;
    bit tail_empty;
    tail_empty = (len == 0) || ($urandom_range(0, 7) == 0);
    for (int j = 0; j < len; j++) begin
      if (filler && $urandom_range(0, 3) == 0) begin
        it = '{action: 1'($urandom), key_byte: 8'($urandom), has_byte: 1'b0, last_byte: 1'b0};
        pending_items.insert(pending_items.size(), it);
        items_queued++;
      end
      it.action = (!tail_empty && j == len - 1) ? act : 1'($urandom);
      it.key_byte = key_content(id, j);
      it.has_byte = 1'b1;
      it.last_byte = !tail_empty && (j == len - 1);
      pending_items.insert(pending_items.size(), it);
      items_queued++;
    end
    if (tail_empty) begin
      it = '{action: act, key_byte: 8'($urandom), has_byte: 1'b0, last_byte: 1'b1};
      pending_items.insert(pending_items.size(), it);
      items_queued++;
    end
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] index, input int value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= CFG_W'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
    if (index == REG_HASH_COUNT) shadow_hash_count = 5'(value);
    else if (index == REG_FILTER_BYTES) shadow_filter_bytes = 11'(value);
  endtask

  // Waits until all items are taken and answered, then lets the back part drain.
  task automatic wait_quiet();
    while (pending_items.size() > 0 || in_ch.valid || expected_answers.size() > 0)
      @(posedge clk);
    repeat (IDLE_GAP) @(posedge clk);
  endtask

  // Random keys: mostly short, some long, a few over the buffer size. Half of
  // the queries repeat an added key so that positive answers are common.
  task automatic random_keys(input int target);
    int stop_at;
    int id;
    int len;
    int pick;
    logic act;
    stop_at = items_queued + target;
    while (items_queued < stop_at) begin
      pick = $urandom_range(0, 99);
      len = (pick < 75) ? $urandom_range(0, 12) :
            (pick < 95) ? $urandom_range(13, MAX_KEY_BYTES) :
                          $urandom_range(MAX_KEY_BYTES + 1, MAX_KEY_BYTES + 8);
      act = $urandom_range(0, 1) ? ACT_QUERY : ACT_ADD;
      if (act == ACT_QUERY && known_ids.size() > 0 && $urandom_range(0, 1)) begin
        id = known_ids[$urandom_range(0, known_ids.size() - 1)];
        len = id % 16;
      end else begin
        id = $urandom_range(2, 1 << 30);
        if (act == ACT_ADD && len <= 15) begin
          id = id - (id % 16) + len;
          known_ids.insert(known_ids.size(), id);
        end
      end
      queue_key(act, id, len, $urandom_range(0, 9) == 0);
    end
  endtask

  initial begin
    int hc_set [6];
    int fb_set [6];
    hc_set = '{1, 30, 0, 31, 3, 12};
    fb_set = '{8, 1024, 3, 2047, 0, 100};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Registers can be written while the block clears its store after reset.
    write_reg(REG_HASH_COUNT, 7);
    write_reg(REG_FILTER_BYTES, 1024);

    // Directed keys: empty key, single bytes at both extremes, all-zero and
    // all-ones keys, the longest key that fits, keys over the limit, and
    // queries of keys that were and were not added.
    queue_key(ACT_QUERY, 5, 0, 1'b0);
    queue_key(ACT_ADD, 5, 0, 1'b0);
    queue_key(ACT_QUERY, 5, 0, 1'b0);
    queue_key(ACT_ADD, 0, 1, 1'b0);
    queue_key(ACT_QUERY, 1, 1, 1'b0);
    queue_key(ACT_ADD, 1, 3, 1'b1);
    queue_key(ACT_QUERY, 1, 3, 1'b0);
    queue_key(ACT_QUERY, 0, 1, 1'b0);
    queue_key(ACT_ADD, 1, MAX_KEY_BYTES, 1'b0);
    queue_key(ACT_QUERY, 1, MAX_KEY_BYTES, 1'b0);
    queue_key(ACT_ADD, 0, MAX_KEY_BYTES + 1, 1'b0);
    queue_key(ACT_QUERY, 1, MAX_KEY_BYTES + 1, 1'b0);
    wait_quiet();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_HASH_COUNT, hc_set[ph]);
      write_reg(REG_FILTER_BYTES, fb_set[ph]);
      // In one phase the receiver holds off while keys keep coming, so the
      // block fills up and stalls its input.
      if (ph == 2) hold_request = 1'b1;
      random_keys(170);
      wait_quiet();  // The sender pauses here until every answer has come.
    end

    // A last run of keys with random register settings.
    write_reg(REG_HASH_COUNT, $urandom_range(1, 30));
    write_reg(REG_FILTER_BYTES, $urandom_range(8, 1024));
    random_keys(60);
    wait_quiet();

    if (mismatches == 0) $display("bloom_filter_engine regression: pass");
    else $display("bloom_filter_engine regression: fail");
    $finish;
  end

  initial begin
    #10ms;
    $display("bloom_filter_engine regression: fail");
    $finish;
  end

endmodule
